// ===== rtl/cpa_pkg.sv =====
// ============================================================================
// cpa_pkg
// Shared widths, constants, tables and cell types of the CPA/TCPA unit.
// ============================================================================
package cpa_pkg;

    localparam int COORD_BITS   = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;

    localparam int SPD_W   = 10;
    localparam int CRS_W   = 12;
    localparam int RX_W    = COORD_BITS + 1;
    localparam int VEL_W   = 24;
    localparam int RV_W    = VEL_W + 1;
    localparam int RV2_W   = 2 * RV_W;
    localparam int DOT_W   = RX_W + RV_W + 1;
    localparam int DIV_W   = RV2_W + 1;
    localparam int Z_W     = 33;
    localparam int P_W     = 34;
    localparam int N_W     = 25;
    localparam int M_W     = 51;
    localparam int S16_W   = 22;
    localparam int G_W     = 52;
    localparam int SQ_W    = 64;
    localparam int QUO_W   = 32;
    localparam int STEP_W  = 5;
    localparam int CPA_W   = 25;
    localparam int TIME_W  = 32;
    localparam int VMAG_W  = 32;

    // Row lengths of the two divide/root sections
    localparam int A_STEPS = 32;
    localparam int B_STEPS = 26;

    // Register positions along the pipeline
    localparam int A_END = 37 + CORDIC_STEPS;
    localparam int B_END = 64 + CORDIC_STEPS;
    localparam int LAT   = 66 + CORDIC_STEPS;

    localparam logic [CRS_W-1:0] FULL_TURN = CRS_W'(3600);
    localparam logic [CRS_W-1:0] HALF_TURN = CRS_W'(1800);
    localparam logic [CRS_W-1:0] Q1_LIMIT  = CRS_W'(900);
    localparam logic [CRS_W-1:0] Q3_LIMIT  = CRS_W'(2700);

    localparam logic [P_W-1:0]          KNOT_Q24    = P_W'(8630938);
    localparam logic [P_W-1:0]          KNOT_RND    = P_W'(1280);
    localparam logic [M_W-1:0]          RECIP5      = M_W'(53687092);
    localparam int                      RECIP5_SH   = 28;
    localparam logic [G_W-1:0]          GAIN_Q30    = G_W'(652032874);
    localparam logic [G_W-1:0]          HALF_Q30    = G_W'(1) << 29;
    localparam logic signed [Z_W-1:0]   DECIDEG_Q30 = Z_W'(1874033);

    typedef struct packed {
        logic signed [VEL_W-1:0] x;
        logic signed [VEL_W-1:0] y;
        logic signed [Z_W-1:0]   z;
        logic                    flip;
    } cord_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] d;
        logic [QUO_W-1:0] feed;
        logic [QUO_W-1:0] quo;
    } div_t;

    typedef struct packed {
        logic [SQ_W-1:0] n;
        logic [SQ_W-1:0] res;
    } sq_t;

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] r;
        case (i)
            5'd0:    r = Z_W'(843314856);
            5'd1:    r = Z_W'(497837829);
            5'd2:    r = Z_W'(263043836);
            5'd3:    r = Z_W'(133525158);
            5'd4:    r = Z_W'(67021686);
            5'd5:    r = Z_W'(33543515);
            5'd6:    r = Z_W'(16775850);
            5'd7:    r = Z_W'(8388437);
            5'd8:    r = Z_W'(4194282);
            5'd9:    r = Z_W'(2097149);
            5'd10:   r = Z_W'(1048575);
            5'd11:   r = Z_W'(524287);
            5'd12:   r = Z_W'(262143);
            5'd13:   r = Z_W'(131071);
            5'd14:   r = Z_W'(65535);
            5'd15:   r = Z_W'(32767);
            5'd16:   r = Z_W'(16383);
            5'd17:   r = Z_W'(8191);
            5'd18:   r = Z_W'(4095);
            5'd19:   r = Z_W'(2047);
            5'd20:   r = Z_W'(1023);
            5'd21:   r = Z_W'(511);
            5'd22:   r = Z_W'(255);
            5'd23:   r = Z_W'(127);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/cpa_cordic_cell.sv =====
// ============================================================================
// cpa_cordic_cell
// One rotation step of the CORDIC row; registered.
// ============================================================================
module cpa_cordic_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [cpa_pkg::STEP_W-1:0]    step,
    input  cpa_pkg::cord_t                c_in,
    output cpa_pkg::cord_t                c_out
);

    cpa_pkg::cord_t c_reg;
    cpa_pkg::cord_t c_next;

    logic signed [cpa_pkg::VEL_W-1:0] xi;
    logic signed [cpa_pkg::VEL_W-1:0] yi;
    logic signed [cpa_pkg::VEL_W-1:0] dx;
    logic signed [cpa_pkg::VEL_W-1:0] dy;
    logic signed [cpa_pkg::Z_W-1:0]   zi;
    logic signed [cpa_pkg::Z_W-1:0]   ang;

    always_comb
    begin
        xi  = c_in.x;
        yi  = c_in.y;
        zi  = c_in.z;
        dx  = yi >>> step;
        dy  = xi >>> step;
        ang = cpa_pkg::atan_q30(step);
        c_next.flip = c_in.flip;
        // rotate toward zero residual angle
        if (!zi[cpa_pkg::Z_W-1])
        begin
            c_next.x = xi - dx;
            c_next.y = yi + dy;
            c_next.z = zi - ang;
        end
        else
        begin
            c_next.x = xi + dx;
            c_next.y = yi - dy;
            c_next.z = zi + ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
        end
    end

    assign c_out = c_reg;

endmodule

// ===== rtl/cpa_div_cell.sv =====
// ============================================================================
// cpa_div_cell
// One restoring-division step: shift in a dividend bit, subtract if it fits.
// ============================================================================
module cpa_div_cell (
    input  logic          clk,
    input  logic          en,
    input  cpa_pkg::div_t d_in,
    output cpa_pkg::div_t d_out
);

    cpa_pkg::div_t d_reg;
    cpa_pkg::div_t d_next;

    logic [cpa_pkg::DIV_W-1:0] r2;

    always_comb
    begin
        r2 = {d_in.rem[cpa_pkg::DIV_W-2:0], d_in.feed[cpa_pkg::QUO_W-1]};
        d_next.d    = d_in.d;
        d_next.feed = {d_in.feed[cpa_pkg::QUO_W-2:0], 1'b0};
        if (r2 >= d_in.d)
        begin
            d_next.rem = r2 - d_in.d;
            d_next.quo = {d_in.quo[cpa_pkg::QUO_W-2:0], 1'b1};
        end
        else
        begin
            d_next.rem = r2;
            d_next.quo = {d_in.quo[cpa_pkg::QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== rtl/cpa_sqrt_cell.sv =====
// ============================================================================
// cpa_sqrt_cell
// One digit step of the integer square root; settles one result bit.
// ============================================================================
module cpa_sqrt_cell (
    input  logic                       clk,
    input  logic                       en,
    input  logic [cpa_pkg::STEP_W-1:0] step,
    input  cpa_pkg::sq_t               s_in,
    output cpa_pkg::sq_t               s_out
);

    cpa_pkg::sq_t s_reg;
    cpa_pkg::sq_t s_next;

    logic [6:0]                 sh;
    logic [cpa_pkg::SQ_W-1:0]   bitv;
    logic [cpa_pkg::SQ_W-1:0]   trial;

    always_comb
    begin
        sh    = 7'd62 - 7'({step, 1'b0});
        bitv  = cpa_pkg::SQ_W'(1) << sh;
        trial = s_in.res + bitv;
        if (s_in.n >= trial)
        begin
            s_next.n   = s_in.n - trial;
            s_next.res = (s_in.res >> 1) + bitv;
        end
        else
        begin
            s_next.n   = s_in.n;
            s_next.res = s_in.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= s_next;
        end
    end

    assign s_out = s_reg;

endmodule

// ===== rtl/closest_point_of_approach_unit.sv =====
// ============================================================================
// closest_point_of_approach_unit
// Throughput: one item per cycle; the whole pipe holds while a result stalls.
// Length is set by the CORDIC row, the 32-cell root/divide row and the
// 26-cell distance divide row. Reset clears only the valid chain.
// ============================================================================
module closest_point_of_approach_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [cpa_pkg::COORD_BITS-1:0] own_east,
    input  logic signed [cpa_pkg::COORD_BITS-1:0] own_north,
    input  logic [cpa_pkg::SPD_W-1:0]             own_speed,
    input  logic [cpa_pkg::CRS_W-1:0]             own_course,
    input  logic signed [cpa_pkg::COORD_BITS-1:0] target_east,
    input  logic signed [cpa_pkg::COORD_BITS-1:0] target_north,
    input  logic [cpa_pkg::SPD_W-1:0]             target_speed,
    input  logic [cpa_pkg::CRS_W-1:0]             target_course,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [cpa_pkg::CPA_W-1:0]             cpa_distance,
    output logic signed [cpa_pkg::TIME_W-1:0]     cpa_time,
    output logic                                  result_valid
);

    localparam int S  = cpa_pkg::CORDIC_STEPS;
    localparam int NA = cpa_pkg::A_STEPS;
    localparam int NB = cpa_pkg::B_STEPS;

    // Advance everything together unless a finished result is held back
    logic en;
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    // Valid chain: the only control state
    logic [cpa_pkg::LAT-1:0] v_reg;
    logic [cpa_pkg::LAT-1:0] v_next;

    assign v_next = {v_reg[cpa_pkg::LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    assign out_valid = v_reg[cpa_pkg::LAT-1];

    // ------------------------------------------------------------------
    // Per-ship front end: course folding, speed scaling, CORDIC start
    // ------------------------------------------------------------------
    logic [cpa_pkg::SPD_W-1:0] spd_in [2];
    logic [cpa_pkg::CRS_W-1:0] crs_in [2];

    assign spd_in[0] = own_speed;
    assign spd_in[1] = target_speed;
    assign crs_in[0] = own_course;
    assign crs_in[1] = target_course;

    logic signed [cpa_pkg::VEL_W-1:0] ve [2];
    logic signed [cpa_pkg::VEL_W-1:0] vn [2];

    for (genvar s = 0; s < 2; s++)
    begin : g_ship
        logic [cpa_pkg::CRS_W-1:0]        crs_w;
        logic signed [cpa_pkg::Z_W-1:0]   ang_next;
        logic                             flip_next;
        logic [cpa_pkg::P_W-1:0]          p_next;
        logic [cpa_pkg::N_W-1:0]          n_w;
        logic [cpa_pkg::M_W-1:0]          m_next;
        logic [cpa_pkg::S16_W-1:0]        s16_w;
        logic [cpa_pkg::G_W-1:0]          g_next;

        logic [cpa_pkg::P_W-1:0]          p_reg;
        logic [cpa_pkg::M_W-1:0]          m_reg;
        logic [cpa_pkg::G_W-1:0]          g_reg;
        logic signed [cpa_pkg::Z_W-1:0]   z_reg [3];
        logic                             f_reg [3];

        cpa_pkg::cord_t cord [S+1];

        always_comb
        begin
            // wrap courses past a full turn, fold into +/- 90 degrees
            crs_w = (crs_in[s] >= cpa_pkg::FULL_TURN) ? crs_in[s] - cpa_pkg::FULL_TURN
                                                      : crs_in[s];
            flip_next = 1'b0;
            if (crs_w > cpa_pkg::Q3_LIMIT)
            begin
                ang_next = cpa_pkg::Z_W'(crs_w) - cpa_pkg::Z_W'(cpa_pkg::FULL_TURN);
            end
            else if (crs_w > cpa_pkg::Q1_LIMIT)
            begin
                ang_next  = cpa_pkg::Z_W'(crs_w) - cpa_pkg::Z_W'(cpa_pkg::HALF_TURN);
                flip_next = 1'b1;
            end
            else
            begin
                ang_next = cpa_pkg::Z_W'(crs_w);
            end
            p_next = cpa_pkg::P_W'(spd_in[s]) * cpa_pkg::KNOT_Q24;
            // divide by 2560: drop 9 bits, then multiply by reciprocal of 5
            n_w    = cpa_pkg::N_W'((p_reg + cpa_pkg::KNOT_RND) >> 9);
            m_next = cpa_pkg::M_W'(n_w) * cpa_pkg::RECIP5;
            s16_w  = cpa_pkg::S16_W'(m_reg >> cpa_pkg::RECIP5_SH);
            g_next = cpa_pkg::G_W'(s16_w) * cpa_pkg::GAIN_Q30;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg    <= p_next;
                z_reg[0] <= ang_next * cpa_pkg::DECIDEG_Q30;
                f_reg[0] <= flip_next;
                m_reg    <= m_next;
                z_reg[1] <= z_reg[0];
                f_reg[1] <= f_reg[0];
                g_reg    <= g_next;
                z_reg[2] <= z_reg[1];
                f_reg[2] <= f_reg[1];
            end
        end

        // start vector: gain-corrected speed on the x axis
        assign cord[0].x    = cpa_pkg::VEL_W'((g_reg + cpa_pkg::HALF_Q30) >> 30);
        assign cord[0].y    = '0;
        assign cord[0].z    = z_reg[2];
        assign cord[0].flip = f_reg[2];

        for (genvar i = 0; i < S; i++)
        begin : g_cord
            cpa_cordic_cell u_cell (
                .clk   (clk),
                .en    (en),
                .step  (cpa_pkg::STEP_W'(i)),
                .c_in  (cord[i]),
                .c_out (cord[i+1])
            );
        end

        // y is the east (sine) part, x the north (cosine) part
        assign ve[s] = cord[S].flip ? -cord[S].y : cord[S].y;
        assign vn[s] = cord[S].flip ? -cord[S].x : cord[S].x;
    end

    // ------------------------------------------------------------------
    // Relative position, delayed to meet the CORDIC output
    // ------------------------------------------------------------------
    logic signed [cpa_pkg::RX_W-1:0] rx_reg [S+3];
    logic signed [cpa_pkg::RX_W-1:0] ry_reg [S+3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0] <= cpa_pkg::RX_W'(target_east) - cpa_pkg::RX_W'(own_east);
            ry_reg[0] <= cpa_pkg::RX_W'(target_north) - cpa_pkg::RX_W'(own_north);
            for (int k = 1; k < S + 3; k++)
            begin
                rx_reg[k] <= rx_reg[k-1];
                ry_reg[k] <= ry_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Products, sums and magnitudes
    // ------------------------------------------------------------------
    logic signed [cpa_pkg::RV_W-1:0]  rvx;
    logic signed [cpa_pkg::RV_W-1:0]  rvy;
    logic signed [cpa_pkg::RX_W-1:0]  rxe;
    logic signed [cpa_pkg::RX_W-1:0]  rye;

    assign rvx = cpa_pkg::RV_W'(ve[1]) - cpa_pkg::RV_W'(ve[0]);
    assign rvy = cpa_pkg::RV_W'(vn[1]) - cpa_pkg::RV_W'(vn[0]);
    assign rxe = rx_reg[S+2];
    assign rye = ry_reg[S+2];

    logic signed [cpa_pkg::DOT_W-1:0] pxx_reg;
    logic signed [cpa_pkg::DOT_W-1:0] pyy_reg;
    logic signed [cpa_pkg::DOT_W-1:0] pxy_reg;
    logic signed [cpa_pkg::DOT_W-1:0] pyx_reg;
    logic signed [cpa_pkg::RV2_W-1:0] sqx_reg;
    logic signed [cpa_pkg::RV2_W-1:0] sqy_reg;

    logic signed [cpa_pkg::DOT_W-1:0] dot_reg;
    logic signed [cpa_pkg::DOT_W-1:0] cross_reg;
    logic [cpa_pkg::RV2_W-1:0]        rv2q_reg;

    logic [cpa_pkg::DOT_W-1:0]        adot_reg;
    logic [cpa_pkg::DOT_W-1:0]        across_reg;
    logic                             dneg_reg;
    logic                             zero_reg;
    logic [cpa_pkg::RV2_W-1:0]        rv2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxx_reg <= cpa_pkg::DOT_W'(rxe) * cpa_pkg::DOT_W'(rvx);
            pyy_reg <= cpa_pkg::DOT_W'(rye) * cpa_pkg::DOT_W'(rvy);
            pxy_reg <= cpa_pkg::DOT_W'(rxe) * cpa_pkg::DOT_W'(rvy);
            pyx_reg <= cpa_pkg::DOT_W'(rye) * cpa_pkg::DOT_W'(rvx);
            sqx_reg <= cpa_pkg::RV2_W'(rvx) * cpa_pkg::RV2_W'(rvx);
            sqy_reg <= cpa_pkg::RV2_W'(rvy) * cpa_pkg::RV2_W'(rvy);

            dot_reg   <= pxx_reg + pyy_reg;
            cross_reg <= pxy_reg - pyx_reg;
            rv2q_reg  <= $unsigned(sqx_reg) + $unsigned(sqy_reg);

            adot_reg   <= dot_reg[cpa_pkg::DOT_W-1] ? $unsigned(-dot_reg) : $unsigned(dot_reg);
            across_reg <= cross_reg[cpa_pkg::DOT_W-1] ? $unsigned(-cross_reg)
                                                      : $unsigned(cross_reg);
            dneg_reg   <= dot_reg[cpa_pkg::DOT_W-1];
            zero_reg   <= (rv2q_reg == '0);
            rv2_reg    <= rv2q_reg;
        end
    end

    // ------------------------------------------------------------------
    // Row A: |v| root and time quotient side by side
    // ------------------------------------------------------------------
    cpa_pkg::div_t tdiv [NA+1];
    cpa_pkg::sq_t  sq   [NA+1];

    // time quotient = floor(|dot| * 2^17 / |v|^2), 32 bits when not saturated
    assign tdiv[0].rem  = cpa_pkg::DIV_W'(adot_reg >> 15);
    assign tdiv[0].d    = cpa_pkg::DIV_W'(rv2_reg);
    assign tdiv[0].feed = {adot_reg[14:0], 17'b0};
    assign tdiv[0].quo  = '0;
    assign sq[0].n      = cpa_pkg::SQ_W'(rv2_reg) << 16;
    assign sq[0].res    = '0;

    for (genvar j = 0; j < NA; j++)
    begin : g_rowa
        cpa_div_cell u_tdiv (
            .clk   (clk),
            .en    (en),
            .d_in  (tdiv[j]),
            .d_out (tdiv[j+1])
        );
        cpa_sqrt_cell u_sqrt (
            .clk   (clk),
            .en    (en),
            .step  (cpa_pkg::STEP_W'(j)),
            .s_in  (sq[j]),
            .s_out (sq[j+1])
        );
    end

    logic [cpa_pkg::DOT_W-1:0] a_across_reg [NA];
    logic                      a_dneg_reg   [NA];
    logic                      a_zero_reg   [NA];
    logic                      a_tovf_reg   [NA];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_across_reg[0] <= across_reg;
            a_dneg_reg[0]   <= dneg_reg;
            a_zero_reg[0]   <= zero_reg;
            // saturate when whole-second quotient reaches 2^15
            a_tovf_reg[0]   <= (adot_reg >> 15) >= cpa_pkg::DOT_W'(rv2_reg);
            for (int k = 1; k < NA; k++)
            begin
                a_across_reg[k] <= a_across_reg[k-1];
                a_dneg_reg[k]   <= a_dneg_reg[k-1];
                a_zero_reg[k]   <= a_zero_reg[k-1];
                a_tovf_reg[k]   <= a_tovf_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Round and saturate the time, hand |v| to row B
    // ------------------------------------------------------------------
    logic [cpa_pkg::QUO_W:0]           tq1;
    logic [cpa_pkg::QUO_W:0]           tmag;
    logic signed [cpa_pkg::TIME_W-1:0] time_next;

    always_comb
    begin
        tq1  = cpa_pkg::QUO_W'(tdiv[NA].quo) + (cpa_pkg::QUO_W + 1)'(1);
        tmag = tq1 >> 1;
        if (!a_dneg_reg[NA-1])
        begin
            // moving apart from a point already passed: negative time
            if (a_tovf_reg[NA-1] || tmag >= (cpa_pkg::QUO_W + 1)'(33'h080000000))
            begin
                time_next = {1'b1, {(cpa_pkg::TIME_W-1){1'b0}}};
            end
            else
            begin
                time_next = cpa_pkg::TIME_W'(-tmag);
            end
        end
        else
        begin
            if (a_tovf_reg[NA-1] || tmag >= (cpa_pkg::QUO_W + 1)'(33'h07fffffff))
            begin
                time_next = {1'b0, {(cpa_pkg::TIME_W-1){1'b1}}};
            end
            else
            begin
                time_next = cpa_pkg::TIME_W'(tmag);
            end
        end
    end

    logic signed [cpa_pkg::TIME_W-1:0] t_time_reg;
    logic                              t_zero_reg;
    logic [cpa_pkg::DOT_W-1:0]         t_across_reg;
    logic [cpa_pkg::VMAG_W-1:0]        t_vmag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_time_reg   <= time_next;
            t_zero_reg   <= a_zero_reg[NA-1];
            t_across_reg <= a_across_reg[NA-1];
            t_vmag_reg   <= sq[NA].res[cpa_pkg::VMAG_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Row B: distance quotient floor(|cross| * 2^9 / |v|_Q24)
    // ------------------------------------------------------------------
    cpa_pkg::div_t cdiv [NB+1];

    assign cdiv[0].rem  = cpa_pkg::DIV_W'(t_across_reg >> 17);
    assign cdiv[0].d    = cpa_pkg::DIV_W'(t_vmag_reg);
    assign cdiv[0].feed = {t_across_reg[16:0], 15'b0};
    assign cdiv[0].quo  = '0;

    for (genvar j = 0; j < NB; j++)
    begin : g_rowb
        cpa_div_cell u_cdiv (
            .clk   (clk),
            .en    (en),
            .d_in  (cdiv[j]),
            .d_out (cdiv[j+1])
        );
    end

    logic signed [cpa_pkg::TIME_W-1:0] b_time_reg [NB];
    logic                              b_zero_reg [NB];
    logic                              b_covf_reg [NB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_time_reg[0] <= t_time_reg;
            b_zero_reg[0] <= t_zero_reg;
            b_covf_reg[0] <= (t_across_reg >> 17) >= cpa_pkg::DOT_W'(t_vmag_reg);
            for (int k = 1; k < NB; k++)
            begin
                b_time_reg[k] <= b_time_reg[k-1];
                b_zero_reg[k] <= b_zero_reg[k-1];
                b_covf_reg[k] <= b_covf_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: round distance half up, saturate, clear on zero |v|
    // ------------------------------------------------------------------
    logic [NB:0]                       cq1;
    logic [NB-1:0]                     cmag;
    logic [cpa_pkg::CPA_W-1:0]         dist_next;
    logic [cpa_pkg::CPA_W-1:0]         dist_reg;
    logic signed [cpa_pkg::TIME_W-1:0] tout_reg;
    logic                              rv_reg;

    always_comb
    begin
        cq1  = (NB + 1)'(cdiv[NB].quo[NB-1:0]) + (NB + 1)'(1);
        cmag = cq1[NB:1];
        if (b_covf_reg[NB-1] || cmag[NB-1])
        begin
            dist_next = '1;
        end
        else
        begin
            dist_next = cmag[cpa_pkg::CPA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= b_zero_reg[NB-1] ? '0 : dist_next;
            tout_reg <= b_zero_reg[NB-1] ? '0 : b_time_reg[NB-1];
            rv_reg   <= !b_zero_reg[NB-1];
        end
    end

    assign cpa_distance = dist_reg;
    assign cpa_time     = tout_reg;
    assign result_valid = rv_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    ast_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_valid |-> cpa_distance == '0 && cpa_time == '0)
        else $error("zero relative velocity result not cleared");

    ast_tdiv_rem: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[cpa_pkg::A_END] && !a_tovf_reg[NA-1] && !a_zero_reg[NA-1]
        |-> tdiv[NA].rem < tdiv[NA].d)
        else $error("time division remainder not below divisor");

    ast_cdiv_rem: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[cpa_pkg::B_END] && !b_covf_reg[NB-1] && !b_zero_reg[NB-1]
        |-> cdiv[NB].rem < cdiv[NB].d)
        else $error("distance division remainder not below divisor");

    ast_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(v_reg[cpa_pkg::LAT-2:0]))
        else $error("pipeline moved while held");

endmodule

// ===== tb/closest_point_of_approach_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// closest_point_of_approach_unit_tb
// Drives vessel pairs into the CPA/TCPA unit with random gaps and output
// stalls. A long output hold-off fills the pipe. Each result item is
// checked, in order, against a bit-exact fixed-point predictor.
// ============================================================================
module closest_point_of_approach_unit_tb;

    // One vessel pair as it goes into the unit
    typedef struct {
        logic signed [cpa_pkg::COORD_BITS-1:0] oe;
        logic signed [cpa_pkg::COORD_BITS-1:0] on;
        logic [cpa_pkg::SPD_W-1:0]             os;
        logic [cpa_pkg::CRS_W-1:0]             oc;
        logic signed [cpa_pkg::COORD_BITS-1:0] te;
        logic signed [cpa_pkg::COORD_BITS-1:0] tn;
        logic [cpa_pkg::SPD_W-1:0]             ts;
        logic [cpa_pkg::CRS_W-1:0]             tc;
    } vessel_pair_t;

    // One CPA/TCPA answer
    typedef struct {
        logic [cpa_pkg::CPA_W-1:0]         dist_m;
        logic signed [cpa_pkg::TIME_W-1:0] tcpa;
        logic                              ok;
    } approach_t;

    // ------------------------------------------------------------------------
    // Approach scoreboard: predict each accepted pair, hold the answers in
    // order, and compare every result item against the oldest one.
    // ------------------------------------------------------------------------
    class approach_board;
        approach_t pending[$];
        int        mismatches;

        // Ship velocity (east, north) in Q16 m/s from speed and course
        static function void ship_vel(input logic [cpa_pkg::SPD_W-1:0] spd,
                                      input logic [cpa_pkg::CRS_W-1:0] crs,
                                      output longint ve, output longint vn);
            longint          a, z, x, y, dx, dy;
            longint unsigned s16;
            bit              flip;
            flip = 0;
            a = longint'(crs);
            if (a >= 3600) a -= 3600;
            if (a > 2700) a -= 3600;
            else if (a > 900)
            begin
                a -= 1800;
                flip = 1;
            end
            z = a * 1874033;
            s16 = (longint'(spd) * 8630938 + 1280) / 2560;
            x = longint'((s16 * 652032874 + (64'd1 << 29)) >> 30);
            y = 0;
            for (int i = 0; i < cpa_pkg::CORDIC_STEPS && i < cpa_pkg::ATAN_LEN; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= cpa_pkg::atan_q30(i[cpa_pkg::STEP_W-1:0]);
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += cpa_pkg::atan_q30(i[cpa_pkg::STEP_W-1:0]);
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            ve = y;
            vn = x;
        endfunction

        static function longint unsigned int_sqrt(input longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        static function approach_t predict_approach(input vessel_pair_t p);
            approach_t       r;
            longint          ve1, vn1, ve2, vn2, rx, ry, vx, vy, dot, crs_p, t;
            longint unsigned rv2, q, rem, mag, vmag, adot, across, cpa;
            ship_vel(p.os, p.oc, ve1, vn1);
            ship_vel(p.ts, p.tc, ve2, vn2);
            rx = longint'(p.te) - longint'(p.oe);
            ry = longint'(p.tn) - longint'(p.on);
            vx = ve2 - ve1;
            vy = vn2 - vn1;
            rv2 = vx * vx + vy * vy;
            if (rv2 == 0)
            begin
                r.dist_m = '0;
                r.tcpa = '0;
                r.ok = 1'b0;
                return r;
            end
            dot = rx * vx + ry * vy;
            crs_p = rx * vy - ry * vx;
            // time: round half away from zero, saturate both ways
            adot = (dot < 0) ? -dot : dot;
            q = adot / rv2;
            rem = adot % rv2;
            if (q >= 32768) mag = 64'd1 << 32;
            else mag = (q << 16) + ((((rem << 17) / rv2) + 1) >> 1);
            if (dot > 0) t = (mag >= 64'd2147483648) ? -64'sd2147483648 : -longint'(mag);
            else t = (mag >= 64'd2147483647) ? 64'sd2147483647 : longint'(mag);
            // distance: round half up, saturate
            vmag = int_sqrt(rv2 << 16);
            across = (crs_p < 0) ? -crs_p : crs_p;
            q = across / vmag;
            rem = across % vmag;
            if (q >= (64'd1 << 17)) cpa = 33554431;
            else
            begin
                cpa = (q << 8) + ((((rem << 9) / vmag) + 1) >> 1);
                if (cpa > 33554431) cpa = 33554431;
            end
            r.dist_m = cpa[cpa_pkg::CPA_W-1:0];
            r.tcpa = t[cpa_pkg::TIME_W-1:0];
            r.ok = 1'b1;
            return r;
        endfunction

        function void note_pair(input vessel_pair_t p);
            pending.push_back(predict_approach(p));
        endfunction

        function void check_result(input approach_t got);
            approach_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: dist=%0d time=%0d ok=%0b",
                             got.dist_m, got.tcpa, got.ok);
                return;
            end
            want = pending.pop_front();
            if (got.dist_m !== want.dist_m || got.tcpa !== want.tcpa || got.ok !== want.ok)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp dist=%0d time=%0d ok=%0b, got dist=%0d time=%0d ok=%0b",
                             want.dist_m, want.tcpa, want.ok, got.dist_m, got.tcpa, got.ok);
            end
        endfunction
    endclass

    logic                                  clk;
    logic                                  rst_n;
    logic                                  in_valid;
    logic                                  in_stall;
    logic signed [cpa_pkg::COORD_BITS-1:0] own_east;
    logic signed [cpa_pkg::COORD_BITS-1:0] own_north;
    logic [cpa_pkg::SPD_W-1:0]             own_speed;
    logic [cpa_pkg::CRS_W-1:0]             own_course;
    logic signed [cpa_pkg::COORD_BITS-1:0] target_east;
    logic signed [cpa_pkg::COORD_BITS-1:0] target_north;
    logic [cpa_pkg::SPD_W-1:0]             target_speed;
    logic [cpa_pkg::CRS_W-1:0]             target_course;
    logic                                  out_valid;
    logic                                  out_stall;
    logic [cpa_pkg::CPA_W-1:0]             cpa_distance;
    logic signed [cpa_pkg::TIME_W-1:0]     cpa_time;
    logic                                  result_valid;

    localparam int RANDOM_ITEMS  = 500;
    localparam int HOLD_AT_ITEM  = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = cpa_pkg::LAT + 20;

    approach_board board;
    int            sent_items;
    bit            hold_done;
    int            idle_cycles;

    closest_point_of_approach_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .own_east(own_east), .own_north(own_north),
        .own_speed(own_speed), .own_course(own_course),
        .target_east(target_east), .target_north(target_north),
        .target_speed(target_speed), .target_course(target_course),
        .out_valid(out_valid), .out_stall(out_stall),
        .cpa_distance(cpa_distance), .cpa_time(cpa_time),
        .result_valid(result_valid)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Offer one pair, hold it until accepted, then note it for prediction
    task automatic send_pair(input vessel_pair_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        own_east      <= p.oe;
        own_north     <= p.on;
        own_speed     <= p.os;
        own_course    <= p.oc;
        target_east   <= p.te;
        target_north  <= p.tn;
        target_speed  <= p.ts;
        target_course <= p.tc;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_pair(p);
        sent_items++;
    endtask

    function automatic vessel_pair_t make_pair(
        input int oe, input int on, input int os, input int oc,
        input int te, input int tn, input int ts, input int tc);
        vessel_pair_t p;
        p.oe = cpa_pkg::COORD_BITS'(oe); p.on = cpa_pkg::COORD_BITS'(on);
        p.os = cpa_pkg::SPD_W'(os);      p.oc = cpa_pkg::CRS_W'(oc);
        p.te = cpa_pkg::COORD_BITS'(te); p.tn = cpa_pkg::COORD_BITS'(tn);
        p.ts = cpa_pkg::SPD_W'(ts);      p.tc = cpa_pkg::CRS_W'(tc);
        return p;
    endfunction

    // Random pair: mostly plausible encounters (nearby, sane courses),
    // the rest full-range noise including courses past a full turn
    function automatic vessel_pair_t random_pair();
        vessel_pair_t p;
        int           roll;
        roll = $urandom_range(99);
        p.oe = cpa_pkg::COORD_BITS'($urandom); p.on = cpa_pkg::COORD_BITS'($urandom);
        p.te = cpa_pkg::COORD_BITS'($urandom); p.tn = cpa_pkg::COORD_BITS'($urandom);
        p.os = cpa_pkg::SPD_W'($urandom);      p.ts = cpa_pkg::SPD_W'($urandom);
        p.oc = cpa_pkg::CRS_W'($urandom);      p.tc = cpa_pkg::CRS_W'($urandom);
        if (roll < 60)
        begin
            // encounter within a few km, courses in range
            p.te = cpa_pkg::COORD_BITS'(int'(p.oe) + int'($urandom_range(20000)) - 10000);
            p.tn = cpa_pkg::COORD_BITS'(int'(p.on) + int'($urandom_range(20000)) - 10000);
            p.oc = cpa_pkg::CRS_W'($urandom_range(3599));
            p.tc = cpa_pkg::CRS_W'($urandom_range(3599));
            p.os = cpa_pkg::SPD_W'($urandom_range(300));
            p.ts = cpa_pkg::SPD_W'($urandom_range(300));
        end
        else if (roll < 68)
        begin
            // same motion: no relative velocity
            p.ts = p.os;
            p.tc = p.oc;
        end
        else if (roll < 75)
        begin
            // nearly the same motion: long times, saturation
            p.ts = p.os;
            p.tc = cpa_pkg::CRS_W'((int'(p.oc) % 3600) + 1);
        end
        return p;
    endfunction

    // Stimulus: directed corners, then random pairs
    initial
    begin
        vessel_pair_t p;
        board = new();
        sent_items = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        own_east = '0; own_north = '0; own_speed = '0; own_course = '0;
        target_east = '0; target_north = '0; target_speed = '0; target_course = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both still, and same motion: result flagged invalid
        send_pair(make_pair(0, 0, 0, 0, 100, 100, 0, 0));
        send_pair(make_pair(5, -7, 1023, 1234, 900, 40, 1023, 1234));
        // coordinate extremes, head-on and crossing
        send_pair(make_pair(-8388608, -8388608, 1023, 450,
                            8388607, 8388607, 1023, 2250));
        send_pair(make_pair(8388607, -8388608, 1023, 0,
                            -8388608, 8388607, 1023, 900));
        send_pair(make_pair(-8388608, 0, 1023, 900, 8388607, 0, 0, 0));
        // quadrant boundaries and wrapped courses
        send_pair(make_pair(0, 0, 500, 0, 1000, 0, 500, 900));
        send_pair(make_pair(0, 0, 500, 900, 1000, 0, 500, 1800));
        send_pair(make_pair(0, 0, 500, 1800, 1000, 0, 500, 2700));
        send_pair(make_pair(0, 0, 500, 2700, 1000, 0, 500, 3599));
        send_pair(make_pair(0, 0, 500, 3600, 1000, 0, 500, 4095));
        send_pair(make_pair(0, 0, 1023, 901, 0, 1000, 1023, 2701));
        send_pair(make_pair(0, 0, 1, 4095, -3000, 2000, 0, 0));
        // tiny relative velocity over a long range: time saturates
        send_pair(make_pair(-8388608, -8388608, 1, 0,
                            8388607, 8388607, 1, 1));
        send_pair(make_pair(8388607, 8388607, 1, 0,
                            -8388608, -8388608, 1, 1));
        // receding and approaching on one line
        send_pair(make_pair(0, 0, 200, 0, 0, 5000, 200, 1800));
        send_pair(make_pair(0, 0, 200, 1800, 0, 5000, 200, 0));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            p = random_pair();
            send_pair(p);
        end
        in_valid <= 1'b0;

        // drain, then let the pipe settle
        while (board.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("closest_point_of_approach_unit_tb: PASS");
        else
            $display("closest_point_of_approach_unit_tb: FAIL");
        $finish;
    end

    // Receiver: check accepted results, then choose next stall. Once, hold
    // off long enough for the pipe to fill and push back on the input.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        hold_done = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_result('{dist_m: cpa_distance, tcpa: cpa_time,
                                     ok: result_valid});
            if (!hold_done && sent_items >= HOLD_AT_ITEM)
            begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // Watchdog: count cycles with no item moving on either side
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("closest_point_of_approach_unit_tb: FAIL");
                $finish;
            end
        end
    end

endmodule

// ===== closest_point_of_approach_unit.f =====
rtl/cpa_pkg.sv
rtl/cpa_cordic_cell.sv
rtl/cpa_div_cell.sv
rtl/cpa_sqrt_cell.sv
rtl/closest_point_of_approach_unit.sv
tb/closest_point_of_approach_unit_tb.sv
